@@ src/vbrhp_pkg.sv @@
// Shared types and constants for the VBR info header parser.
package vbrhp_pkg;

  // Number of seek-table entries in a header (1 to 128).
  localparam int unsigned TocSize = 100;

  // Tag words as they stand in the shift register after four bytes.
  localparam logic [31:0] TagInfo = 32'h496E_666F;
  localparam logic [31:0] TagXing = 32'h5869_6E67;

  localparam logic [6:0] CountMax = 7'd127;
  localparam logic [6:0] WordLastByte = 7'd3;

  // Parse phases, one-hot.
  typedef enum logic [6:0] {
    PhTag    = 7'b0000001,
    PhFlags  = 7'b0000010,
    PhFrames = 7'b0000100,
    PhBytes  = 7'b0001000,
    PhToc    = 7'b0010000,
    PhScale  = 7'b0100000,
    PhIdle   = 7'b1000000
  } phase_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KindToc    = 2'd0,
    KindDone   = 2'd1,
    KindBadTag = 2'd2,
    KindTrunc  = 2'd3
  } kind_e;

  // One input byte with its side flags.
  typedef struct packed {
    logic       restart;
    logic       final_byte;
    logic [7:0] data_byte;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    kind_e       kind;
    logic        done_res;
    logic [6:0]  bytes_consumed;
    logic [31:0] quality_scale;
    logic [31:0] stream_bytes;
    logic [31:0] frame_total;
    logic [3:0]  present_flags;
    logic        version;
    logic [7:0]  toc_value;
    logic [6:0]  toc_index;
  } res_t;

endpackage

@@ src/vbr_info_header_parser.sv @@
// Top level of the MP3 Xing/Info VBR header parser.
//
// The slave stream carries one header byte per transaction in tdata; tuser
// marks the first byte of a new header and tlast marks a byte after which no
// more data is available. The parser checks the "Info" or "Xing" tag, reads
// the flags word and the fields it selects, and reports each seek-table byte
// as it arrives. A closing transaction (tlast high on the master stream)
// carries the whole header summary, a bad-tag error or a truncated status;
// tuser gives the kind of each result transaction.
// An accepted byte sits in the input register and is parsed by the step logic
// on its way into the result register, from which its result is offered on
// the master side. Throughput is one byte per cycle while the receiver does
// not stall a pending result, also for bytes that cause no result.
// Reset empties both registers and puts the parser at the tag, so a header
// can start without a restart mark. While the receiver stalls a pending
// result, the byte in the input register waits as well, whether or not it
// yields a result, and the slave side takes no new byte once that register
// is full.
module vbr_info_header_parser
  import vbrhp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic         s_axis_tuser_i,   // [0] restart
  input  logic         s_axis_tlast_i,   // final_byte
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,   // [6:0] toc_index, [14:7] toc_value,
                                         // [15] version, [19:16] present_flags,
                                         // [51:20] frame_total,
                                         // [83:52] stream_bytes,
                                         // [115:84] quality_scale,
                                         // [122:116] bytes_consumed, rest zero
  output logic [1:0]   m_axis_tuser_o,   // [1:0] kind
  output logic         m_axis_tlast_o    // done_res
);

  in_item_t s_item;
  in_item_t item_q;
  logic     item_valid;
  logic     advance;
  logic     res_valid;
  res_t     res_c;
  res_t     res_q;

  assign s_item.restart    = s_axis_tuser_i;
  assign s_item.final_byte = s_axis_tlast_i;
  assign s_item.data_byte  = s_axis_tdata_i;

  // The held byte is parsed when its result, if any, has room to land.
  assign advance = item_valid && (!m_axis_tvalid_o || m_axis_tready_i);

  vbrhp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (s_item),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item_q)
  );

  vbrhp_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (item_q),
    .res_valid_o (res_valid),
    .res_o       (res_c)
  );

  vbrhp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_valid),
    .res_i   (res_c),
    .ready_i (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .res_o   (res_q)
  );

  assign m_axis_tdata_o = {5'd0, res_q.bytes_consumed, res_q.quality_scale,
                           res_q.stream_bytes, res_q.frame_total,
                           res_q.present_flags, res_q.version,
                           res_q.toc_value, res_q.toc_index};
  assign m_axis_tuser_o = res_q.kind;
  assign m_axis_tlast_o = res_q.done_res;

endmodule

@@ src/vbrhp_in_reg.sv @@
// Input register stage of the VBR info header parser.
module vbrhp_in_reg
  import vbrhp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  input  logic     advance_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  // The stage takes a new byte when empty or when its byte moves on this cycle.
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ src/vbrhp_parse_core.sv @@
// Parse state and the per-byte step logic of the VBR info header parser.
module vbrhp_parse_core
  import vbrhp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  output logic     res_valid_o,
  output res_t     res_o
);

  phase_e      phase_q, phase_d, e_phase;
  logic [6:0]  fbc_q, fbc_d, e_fbc;
  logic [31:0] sw_q, sw_d, e_sw, sw_new;
  logic [3:0]  flags_q, flags_d, e_flags;
  logic        ver_q, ver_d, e_ver;
  logic [31:0] frames_q, frames_d, e_frames;
  logic [31:0] bytes_q, bytes_d, e_bytes;
  logic [6:0]  cons_q, cons_d, e_cons;
  logic [7:0]  fbc_inc;
  logic        word_done;
  logic        bad;
  logic        is_toc;
  logic [31:0] quality;
  kind_e       kind;

  // Next phase after 'from' whose flag bit is set, or idle.
  function automatic phase_e next_after(phase_e from, logic [3:0] f);
    logic [3:0] m;
    phase_e     r;
    case (from)
      PhFlags:  m = f;
      PhFrames: m = {f[3:1], 1'b0};
      PhBytes:  m = {f[3:2], 2'b00};
      PhToc:    m = {f[3], 3'b000};
      default:  m = 4'b0000;
    endcase
    if (m[0]) begin
      r = PhFrames;
    end else if (m[1]) begin
      r = PhBytes;
    end else if (m[2]) begin
      r = PhToc;
    end else if (m[3]) begin
      r = PhScale;
    end else begin
      r = PhIdle;
    end
    return r;
  endfunction

  always_comb begin
    // A restart clears the parse state before this byte is taken.
    e_phase  = item_i.restart ? PhTag : phase_q;
    e_fbc    = item_i.restart ? 7'd0 : fbc_q;
    e_sw     = item_i.restart ? 32'd0 : sw_q;
    e_flags  = item_i.restart ? 4'd0 : flags_q;
    e_ver    = item_i.restart ? 1'b0 : ver_q;
    e_frames = item_i.restart ? 32'd0 : frames_q;
    e_bytes  = item_i.restart ? 32'd0 : bytes_q;
    e_cons   = item_i.restart ? 7'd0 : cons_q;

    phase_d  = e_phase;
    fbc_d    = e_fbc;
    sw_d     = e_sw;
    flags_d  = e_flags;
    ver_d    = e_ver;
    frames_d = e_frames;
    bytes_d  = e_bytes;
    cons_d   = e_cons;

    sw_new    = {e_sw[23:0], item_i.data_byte};
    fbc_inc   = {1'b0, e_fbc} + 8'd1;
    word_done = (e_fbc == WordLastByte);
    bad       = 1'b0;
    is_toc    = 1'b0;
    quality   = 32'd0;
    kind      = KindToc;
    res_valid_o = 1'b0;

    if (e_phase != PhIdle) begin
      cons_d = (e_cons != CountMax) ? e_cons + 7'd1 : e_cons;
      sw_d   = sw_new;
      if (e_phase != PhToc) begin
        fbc_d = word_done ? 7'd0 : fbc_inc[6:0];
      end
      case (e_phase)
        PhTag: begin
          if (word_done) begin
            if (sw_new == TagInfo) begin
              ver_d   = 1'b0;
              phase_d = PhFlags;
            end else if (sw_new == TagXing) begin
              ver_d   = 1'b1;
              phase_d = PhFlags;
            end else begin
              bad = 1'b1;
            end
          end
        end
        PhFlags: begin
          if (word_done) begin
            flags_d = sw_new[3:0];
            phase_d = next_after(PhFlags, sw_new[3:0]);
          end
        end
        PhFrames: begin
          if (word_done) begin
            frames_d = sw_new;
            phase_d  = next_after(PhFrames, e_flags);
          end
        end
        PhBytes: begin
          if (word_done) begin
            bytes_d = sw_new;
            phase_d = next_after(PhBytes, e_flags);
          end
        end
        PhToc: begin
          is_toc = 1'b1;
          if (fbc_inc >= 8'(TocSize)) begin
            fbc_d   = 7'd0;
            phase_d = next_after(PhToc, e_flags);
          end else begin
            fbc_d = fbc_inc[6:0];
          end
        end
        PhScale: begin
          if (word_done) begin
            quality = sw_new;
            phase_d = PhIdle;
          end
        end
        default: begin
          phase_d = e_phase;
        end
      endcase

      if (bad) begin
        kind        = KindBadTag;
        res_valid_o = 1'b1;
      end else if (phase_d == PhIdle) begin
        kind        = KindDone;
        res_valid_o = 1'b1;
      end else if (item_i.final_byte) begin
        kind        = KindTrunc;
        res_valid_o = 1'b1;
      end else if (is_toc) begin
        kind        = KindToc;
        res_valid_o = 1'b1;
      end
      // Any ending result closes the header until the next restart.
      if (res_valid_o && (kind != KindToc)) begin
        phase_d = PhIdle;
      end
    end

    res_o.kind           = kind;
    res_o.done_res       = (kind != KindToc);
    res_o.bytes_consumed = cons_d;
    res_o.quality_scale  = (kind == KindDone) ? quality : 32'd0;
    res_o.stream_bytes   = bytes_d;
    res_o.frame_total    = frames_d;
    res_o.present_flags  = flags_d;
    res_o.version        = ver_d;
    res_o.toc_value      = is_toc ? item_i.data_byte : 8'd0;
    res_o.toc_index      = is_toc ? e_fbc : 7'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhTag;
      fbc_q    <= 7'd0;
      sw_q     <= 32'd0;
      flags_q  <= 4'd0;
      ver_q    <= 1'b0;
      frames_q <= 32'd0;
      bytes_q  <= 32'd0;
      cons_q   <= 7'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      fbc_q    <= fbc_d;
      sw_q     <= sw_d;
      flags_q  <= flags_d;
      ver_q    <= ver_d;
      frames_q <= frames_d;
      bytes_q  <= bytes_d;
      cons_q   <= cons_d;
    end
  end

endmodule

@@ src/vbrhp_out_reg.sv @@
// Result register stage of the VBR info header parser.
module vbrhp_out_reg
  import vbrhp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic ready_i,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
